// ----- sv/tsit_pkg.sv -----
// Shared types, codes and constants of the time-sorted insertion table.
`default_nettype none

package tsit_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int OPCODE_W     = 2;
  localparam int WORD_W       = 32;
  localparam int READ_INDEX_W = 6;
  localparam int STATUS_W     = 2;
  localparam int POS_W        = 7;
  localparam int ENTRY_W      = 4 * WORD_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PLACE,
    S_RESULT,
    S_RESULT_READ
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_INDEX,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW_ABOVE,
    WR_NEW_ZERO
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_CLEAR
  } cnt_op_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,
    POS_INDEX,
    POS_ABOVE
  } pos_sel_t;

  typedef struct packed {
    logic [WORD_W-1:0] tstamp;
    logic [WORD_W-1:0] lvl_low;
    logic [WORD_W-1:0] lvl_mid;
    logic [WORD_W-1:0] lvl_high;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     set_verdict;
    status_t  verdict;
    rd_sel_t  rd;
    wr_sel_t  wr;
    cnt_op_t  cnt;
    pos_sel_t pos;
    logic     rsp_load;
    logic     show_entry;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    empty;
    logic    idx_bad;
    logic    later;
    logic    ptr_zero;
    logic    rsp_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/time_sorted_insert_table_unit.sv -----
// Top level of the time-sorted insertion table: controller plus datapath.
//
// Usage: a request word (opcode, new_time, band words, read_index) enters on
// req_valid / req_stall; it is taken at an edge with req_valid high and
// req_stall low. Each request gives exactly one response word on
// rsp_valid / rsp_stall (status, position, entry_count and entry fields).
// Insert places the entry after every stored entry with an equal or earlier
// time; read returns the entry at read_index; clear empties the table.
// Timing: one request at a time. An insert scans down from the top and moves
// each stored entry with a later time up one slot through the table
// memory's single write port, one entry per cycle, before it writes the new
// entry; read, clear, a dropped insert and the spare opcode do no scan.
// The response register is loaded as the block returns to idle, so the
// next request is taken while an earlier response still waits.
// Stall: a stalled response holds; a finished item waits in its result state
// until the response register is free, and req_stall stays high meanwhile.
// Reset (rst, synchronous): empties the table and drops any pending
// response; the table memory itself is not cleared and needs no sweep.
`default_nettype none

module time_sorted_insert_table_unit import tsit_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire logic [OPCODE_W-1:0]     opcode,
  input  wire logic [WORD_W-1:0]       new_time,
  input  wire logic [WORD_W-1:0]       band_low,
  input  wire logic [WORD_W-1:0]       band_mid,
  input  wire logic [WORD_W-1:0]       band_high,
  input  wire logic [READ_INDEX_W-1:0] read_index,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output logic      [STATUS_W-1:0]     status,
  output logic      [POS_W-1:0]        position,
  output logic      [POS_W-1:0]        entry_count,
  output logic      [WORD_W-1:0]       entry_time,
  output logic      [WORD_W-1:0]       entry_low,
  output logic      [WORD_W-1:0]       entry_mid,
  output logic      [WORD_W-1:0]       entry_high
);

  // Commands from the sequencer, status back from the datapath
  cmd_t  cmd;
  stat_t stat;

  tsit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table memory, scan pointer, count and the response register
  tsit_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .new_time    (new_time),
    .band_low    (band_low),
    .band_mid    (band_mid),
    .band_high   (band_high),
    .read_index  (read_index),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count),
    .entry_time  (entry_time),
    .entry_low   (entry_low),
    .entry_mid   (entry_mid),
    .entry_high  (entry_high)
  );

endmodule

`default_nettype wire

// ----- sv/tsit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsit_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tsit_ctrl.sv -----
// Sequencer for insert, read and clear operations on the sorted table.
`default_nettype none

module tsit_ctrl import tsit_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full)       state_next = S_RESULT;
            else if (stat.empty) state_next = S_PLACE;
            else                 state_next = S_SCAN;
          end
          OP_READ: begin
            state_next = stat.idx_bad ? S_RESULT : S_RESULT_READ;
          end
          OP_CLEAR, OP_NONE: state_next = S_RESULT;
        endcase
      end
      S_SCAN: begin
        if (!stat.later)        state_next = S_RESULT;
        else if (stat.ptr_zero) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_RESULT;
      S_RESULT, S_RESULT_READ: begin
        if (stat.rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
      end
      S_DECODE: begin
        cmd.set_verdict = 1'b1;
        cmd.verdict     = STAT_OK;
        cmd.pos         = POS_ZERO;
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.verdict = STAT_FULL;
            end else if (!stat.empty) begin
              cmd.rd = RD_TOP;
            end
          end
          OP_READ: begin
            cmd.pos = POS_INDEX;
            if (stat.idx_bad) cmd.verdict = STAT_RANGE;
            else              cmd.rd      = RD_INDEX;
          end
          OP_CLEAR: cmd.cnt = CNT_CLEAR;
          OP_NONE:  cmd.cnt = CNT_HOLD;
        endcase
      end
      S_SCAN: begin
        if (stat.later) begin
          // Move the later entry up one slot; carry on downwards until slot zero
          cmd.wr = WR_SHIFT;
          if (stat.ptr_zero) cmd.pos = POS_ZERO;
          else               cmd.rd  = RD_NEXT;
        end else begin
          cmd.wr  = WR_NEW_ABOVE;
          cmd.pos = POS_ABOVE;
          cmd.cnt = CNT_INC;
        end
      end
      S_PLACE: begin
        cmd.wr  = WR_NEW_ZERO;
        cmd.pos = POS_ZERO;
        cmd.cnt = CNT_INC;
      end
      S_RESULT: begin
        cmd.rsp_load = stat.rsp_free;
      end
      S_RESULT_READ: begin
        cmd.rsp_load   = stat.rsp_free;
        cmd.show_entry = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tsit_datapath.sv -----
// Item registers, table memory, scan pointer, count and result register.
`default_nettype none

module tsit_datapath import tsit_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  input  wire logic [OPCODE_W-1:0]     opcode,
  input  wire logic [WORD_W-1:0]       new_time,
  input  wire logic [WORD_W-1:0]       band_low,
  input  wire logic [WORD_W-1:0]       band_mid,
  input  wire logic [WORD_W-1:0]       band_high,
  input  wire logic [READ_INDEX_W-1:0] read_index,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output logic      [STATUS_W-1:0]     status,
  output logic      [POS_W-1:0]        position,
  output logic      [POS_W-1:0]        entry_count,
  output logic      [WORD_W-1:0]       entry_time,
  output logic      [WORD_W-1:0]       entry_low,
  output logic      [WORD_W-1:0]       entry_mid,
  output logic      [WORD_W-1:0]       entry_high
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > READ_INDEX_W) ? CNT_W : READ_INDEX_W;

  opcode_t                 op_q;
  entry_t                  item;
  logic [READ_INDEX_W-1:0] idx_q;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        ptr;
  logic [IDX_W-1:0]        ptr_up;
  logic [POS_W-1:0]        pos;
  status_t                 verdict;

  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_wr_addr;
  entry_t                  ram_wr_data;
  logic                    ram_rd_en;
  logic [IDX_W-1:0]        ram_rd_addr;
  entry_t                  ram_rd_data;

  assign ptr_up = ptr + IDX_W'(1);

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q          <= opcode_t'(opcode);
      item.tstamp   <= new_time;
      item.lvl_low  <= band_low;
      item.lvl_mid  <= band_mid;
      item.lvl_high <= band_high;
      idx_q         <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt)
        CNT_INC:   count <= count + CNT_W'(1);
        CNT_CLEAR: count <= '0;
        default:   count <= count;
      endcase
    end
  end

  // Scan pointer: the slot whose read data is on the RAM output
  always_ff @(posedge clk) begin
    case (cmd.rd)
      RD_TOP:  ptr <= IDX_W'(count - CNT_W'(1));
      RD_NEXT: ptr <= ptr - IDX_W'(1);
      default: ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.pos)
      POS_ZERO:  pos <= '0;
      POS_INDEX: pos <= POS_W'(idx_q);
      POS_ABOVE: pos <= POS_W'(ptr_up);
      default:   pos <= pos;
    endcase
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict;
    end
  end

  always_comb begin
    ram_rd_en   = (cmd.rd != RD_NONE);
    ram_rd_addr = '0;
    unique case (cmd.rd)
      RD_TOP:   ram_rd_addr = IDX_W'(count - CNT_W'(1));
      RD_INDEX: ram_rd_addr = IDX_W'(idx_q);
      RD_NEXT:  ram_rd_addr = ptr - IDX_W'(1);
      RD_NONE:  ram_rd_addr = '0;
    endcase
  end

  always_comb begin
    ram_wr_en   = (cmd.wr != WR_NONE);
    ram_wr_addr = ptr_up;
    ram_wr_data = item;
    unique case (cmd.wr)
      WR_SHIFT: begin
        ram_wr_addr = ptr_up;
        ram_wr_data = ram_rd_data;
      end
      WR_NEW_ABOVE: begin
        ram_wr_addr = ptr_up;
        ram_wr_data = item;
      end
      WR_NEW_ZERO: begin
        ram_wr_addr = '0;
        ram_wr_data = item;
      end
      WR_NONE: begin
        ram_wr_addr = ptr_up;
        ram_wr_data = item;
      end
    endcase
  end

  tsit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      status      <= verdict;
      position    <= pos;
      entry_count <= POS_W'(count);
      if (cmd.show_entry) begin
        entry_time <= ram_rd_data.tstamp;
        entry_low  <= ram_rd_data.lvl_low;
        entry_mid  <= ram_rd_data.lvl_mid;
        entry_high <= ram_rd_data.lvl_high;
      end else begin
        entry_time <= '0;
        entry_low  <= '0;
        entry_mid  <= '0;
        entry_high <= '0;
      end
    end
  end

  always_comb begin
    stat.op       = op_q;
    stat.full     = (count == CNT_W'(DEPTH));
    stat.empty    = (count == '0);
    stat.idx_bad  = (CMP_W'(idx_q) >= CMP_W'(count));
    stat.later    = (ram_rd_data.tstamp > item.tstamp);
    stat.ptr_zero = (ptr == '0);
    stat.rsp_free = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire
